[rtl/text_line_number_visible_filter_macros.svh]
// assertion helpers for the listing filter
`ifndef TEXT_LINE_NUMBER_VISIBLE_FILTER_MACROS_SVH
`define TEXT_LINE_NUMBER_VISIBLE_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TLNF_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tlnf check failed");
// next-cycle implication
`define TLNF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlnf check failed");
`else
`define TLNF_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define TLNF_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

[rtl/tlnf_pkg.sv]
package tlnf_pkg;

	localparam int NUM_DIGITS = 6;
	localparam int BODY_MAX   = 4;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [3:0] TAB_POS  = 4'd6;
	localparam logic [3:0] BODY_POS = 4'd7;

	localparam logic [23:0] BCD_ONE = 24'h000001;
	localparam logic [23:0] BCD_MAX = 24'h999999;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_HIGH   = 8'h80;
	localparam logic [7:0] CH_META_P = 8'hA0;
	localparam logic [7:0] CH_FF     = 8'hFF;

	typedef enum logic [2:0] {
		REG_NUM_ALL,
		REG_NUM_NONBLANK,
		REG_SQUEEZE,
		REG_SHOW_ENDS,
		REG_SHOW_TABS,
		REG_SHOW_NONPRINT
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       file_start;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_t;

	typedef struct packed {
		logic number_all_lines;
		logic number_nonblank_lines;
		logic squeeze_blank;
		logic show_line_ends;
		logic show_tabs;
		logic show_nonprinting;
	} cfg_t;

	// one queued run: optional number prefix and one to four body bytes
	typedef struct packed {
		logic                     num_en;
		logic [23:0]              number;
		logic [BODY_MAX-1:0][7:0] body;
		logic [1:0]               body_last;
	} run_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[rtl/tlnf_front.sv]
module tlnf_front import tlnf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  in_t        in_data,
	input  q_stat_t    q_stat,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic       cfg_data,
	output logic       push,
	output run_t       push_run
);

	cfg_t        cfg_q;
	logic [23:0] bcd_q;
	logic        prev_nl_q;
	logic        nas_q;
	logic [1:0]  blank_run_q;

	logic        accept;
	logic [7:0]  c;
	logic        is_nl;
	logic        is_tab;
	logic [1:0]  br;
	logic        nas;
	logic        drop;
	logic        show_num;
	logic        literal;
	logic [1:0]  br_n;
	logic        nas_n;
	logic        prev_nl_n;
	logic [23:0] bcd_n;
	logic [BODY_MAX-1:0][7:0] body;
	logic [1:0]  body_last;

	function automatic logic [23:0] bcd_inc(input logic [23:0] v);
		logic [23:0] r;
		logic        carry;
		r = v;
		carry = 1'b1;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (carry) begin
				if (v[4*i +: 4] == 4'd9) begin
					r[4*i +: 4] = 4'd0;
				end else begin
					r[4*i +: 4] = v[4*i +: 4] + 4'd1;
					carry = 1'b0;
				end
			end
		end
		return r;
	endfunction

	assign accept = in_valid && !q_stat.full;
	assign c      = in_data.in_byte;
	assign is_nl  = (c == CH_NL);
	assign is_tab = (c == CH_TAB);

	always_comb begin
		br  = in_data.file_start ? 2'd0 : blank_run_q;
		nas = in_data.file_start ? 1'b0 : nas_q;

		drop = 1'b0;
		br_n = 2'd2;
		if (cfg_q.squeeze_blank && is_nl) begin
			if (br == 2'd1) begin
				drop = 1'b1;
				br_n = br;
			end else begin
				br_n = (br == 2'd0) ? 2'd1 : 2'd0;
			end
		end

		show_num = !drop && !nas && prev_nl_q &&
			((!cfg_q.number_nonblank_lines && cfg_q.number_all_lines) ||
			 (cfg_q.number_nonblank_lines && !is_nl));

		body      = '0;
		body_last = 2'd0;
		literal   = 1'b0;
		if (cfg_q.show_nonprinting && !is_tab && !is_nl) begin
			if (c >= CH_SPACE && c < CH_DEL) begin
				body[0] = c;
			end else if (c == CH_DEL) begin
				body[0] = CH_CARET;
				body[1] = CH_QMARK;
				body_last = 2'd1;
			end else if (c == CH_FF) begin
				body[0] = CH_M;
				body[1] = CH_DASH;
				body[2] = CH_CARET;
				body[3] = CH_QMARK;
				body_last = 2'd3;
			end else if (c >= CH_META_P) begin
				body[0] = CH_M;
				body[1] = CH_DASH;
				body[2] = {1'b0, c[6:0]};
				body_last = 2'd2;
			end else if (c >= CH_HIGH) begin
				body[0] = CH_M;
				body[1] = CH_DASH;
				body[2] = CH_CARET;
				body[3] = {2'b01, c[5:0]};
				body_last = 2'd3;
			end else begin
				body[0] = CH_CARET;
				body[1] = {2'b01, c[5:0]};
				body_last = 2'd1;
			end
		end else if (cfg_q.show_line_ends && is_nl) begin
			body[0] = CH_DOLLAR;
			body[1] = c;
			body_last = 2'd1;
			literal = 1'b1;
		end else if (cfg_q.show_tabs && is_tab) begin
			body[0] = CH_CARET;
			body[1] = CH_I;
			body_last = 2'd1;
		end else begin
			body[0] = c;
			literal = 1'b1;
		end

		nas_n     = show_num ? 1'b1 : nas;
		prev_nl_n = prev_nl_q;
		if (!drop && literal) begin
			nas_n     = 1'b0;
			prev_nl_n = is_nl;
		end

		bcd_n = bcd_q;
		if (show_num && bcd_q != BCD_MAX) begin
			bcd_n = bcd_inc(bcd_q);
		end
	end

	assign push               = accept && !drop;
	assign push_run.num_en    = show_num;
	assign push_run.number    = bcd_q;
	assign push_run.body      = body;
	assign push_run.body_last = body_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_ALL:       cfg_q.number_all_lines      <= cfg_data;
				REG_NUM_NONBLANK:  cfg_q.number_nonblank_lines <= cfg_data;
				REG_SQUEEZE:       cfg_q.squeeze_blank         <= cfg_data;
				REG_SHOW_ENDS:     cfg_q.show_line_ends        <= cfg_data;
				REG_SHOW_TABS:     cfg_q.show_tabs             <= cfg_data;
				REG_SHOW_NONPRINT: cfg_q.show_nonprinting      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q       <= BCD_ONE;
			prev_nl_q   <= 1'b1;
			nas_q       <= 1'b0;
			blank_run_q <= 2'd0;
		end else if (accept) begin
			bcd_q       <= bcd_n;
			prev_nl_q   <= prev_nl_n;
			nas_q       <= nas_n;
			blank_run_q <= br_n;
		end
	end

endmodule

[rtl/tlnf_queue.sv]
module tlnf_queue import tlnf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  run_t    push_run,
	input  logic    pop,
	output run_t    head,
	output q_stat_t q_stat
);

	run_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head         = mem[rd_ptr_q];
	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/tlnf_back.sv]
module tlnf_back import tlnf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  run_t    head,
	input  q_stat_t q_stat,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_stall,
	output out_t    out_data
);

	logic [3:0] pos_q;
	logic       out_valid_q;
	out_t       out_q;

	logic [3:0] sel;
	logic [1:0] body_idx;
	logic [NUM_DIGITS-1:0][7:0] num_chars;
	logic       lead;
	logic [3:0] d;
	logic [7:0] byte_n;
	logic       last_n;
	logic       load;

	// digit chars, most significant first, leading zeros blanked
	always_comb begin
		lead = 1'b1;
		for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
			d = head.number[4*i +: 4];
			lead = lead && (d == 4'd0) && (i > 0);
			num_chars[NUM_DIGITS-1-i] = lead ? CH_SPACE : {4'h3, d};
		end
	end

	assign sel      = head.num_en ? pos_q : pos_q + BODY_POS;
	assign body_idx = 2'(sel - BODY_POS);

	always_comb begin
		last_n = 1'b0;
		if (sel < TAB_POS) begin
			byte_n = num_chars[sel[2:0]];
		end else if (sel == TAB_POS) begin
			byte_n = CH_TAB;
		end else begin
			byte_n = head.body[body_idx];
			last_n = (body_idx == head.body_last);
		end
	end

	assign load = (!out_valid_q || !out_stall) && !q_stat.empty;
	assign pop  = load && last_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= !q_stat.empty;
			end
			if (load) begin
				pos_q <= last_n ? 4'd0 : pos_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= byte_n;
			out_q.run_last <= last_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/text_line_number_visible_filter.sv]
// channel  dir  handshake            beat
// in       in   in_valid/in_stall    in_data: in_byte, file_start
// out      out  out_valid/out_stall  out_data: out_byte, run_last
// cfg      in   cfg_we               cfg_index, cfg_data
//
// one input beat per cycle while the two-entry run queue has room
// each run drains at one output byte per cycle while out_stall is low, 0 to 11 bytes per input beat
// a squeezed blank line gives no output and takes no queue entry
// output is registered; a run's first byte is loaded from the queue head when out_stall allows
// arst_n clears config, line counter (to 1) and queue; no clearing pass
`include "text_line_number_visible_filter_macros.svh"

module text_line_number_visible_filter import tlnf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_data,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic       cfg_data
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	run_t    push_run;
	run_t    head;

	assign in_stall = q_stat.full;

	tlnf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_data  (in_data),
		.q_stat   (q_stat),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.push_run (push_run)
	);

	tlnf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_run(push_run),
		.pop     (pop),
		.head    (head),
		.q_stat  (q_stat)
	);

	tlnf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// a queued run is visible to the back end on the next cycle
	`TLNF_ASSERT_NEXT(a_push_fills, clk, arst_n, push, !q_stat.empty)
	// a run only retires from a non-empty queue
	`TLNF_ASSERT_NOW(a_pop_nonempty, clk, arst_n, pop, !q_stat.empty)
	// a new output beat comes from a queued run
	`TLNF_ASSERT_NOW(a_out_source, clk, arst_n, $rose(out_valid), $past(!q_stat.empty))

endmodule

[bench/testbench.sv]
module testbench import tlnf_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int BURST_ITEMS  = 50;
	localparam logic [7:0] CH_ZERO = 8'h30;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_t        in_data;
	logic       out_valid;
	logic       out_stall;
	out_t       out_data;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic       cfg_data;

	// listing bytes still owed by the block, oldest first
	out_t listing_q[$];

	// predictor copy of options and line state
	cfg_t       opts;
	logic [23:0] line_bcd;
	logic [7:0]  last_literal;
	logic        number_shown;
	logic [1:0]  blank_run;

	int src_idle_pct;
	int sink_stall_pct;
	int cycles;
	int bytes_sent;
	int beats_checked;
	int mismatches;
	int settings_used;

	text_line_number_visible_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles, listing_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	function automatic void bump_line_number();
		logic       done;
		logic [3:0] d;
		int         i;
		done = (line_bcd == BCD_MAX);
		for (i = 0; i < 6; i++) begin
			if (!done) begin
				d = line_bcd[4*i +: 4];
				line_bcd[4*i +: 4] = (d < 4'd9) ? d + 4'd1 : 4'd0;
				done = (d < 4'd9);
			end
		end
	endfunction

	function automatic void predict_listing(input logic [7:0] b, input logic fs);
		logic [7:0] run[$];
		logic       want_number;
		logic       started;
		logic [3:0] d;
		int         i;
		if (fs) begin
			blank_run = 2'd0;
			number_shown = 1'b0;
		end
		if (opts.squeeze_blank && b == CH_NL) begin
			// second empty line in a row vanishes
			if (blank_run == 2'd1)
				return;
			blank_run = (blank_run == 2'd0) ? 2'd1 : 2'd0;
		end else begin
			blank_run = 2'd2;
		end
		want_number = (last_literal == CH_NL) &&
			(opts.number_nonblank_lines ? (b != CH_NL) : opts.number_all_lines);
		if (want_number && !number_shown) begin
			started = 1'b0;
			for (i = 5; i >= 0; i--) begin
				d = line_bcd[4*i +: 4];
				if (d == 4'd0 && !started && i > 0) begin
					run.push_back(CH_SPACE);
				end else begin
					started = 1'b1;
					run.push_back(CH_ZERO + 8'(d));
				end
			end
			run.push_back(CH_TAB);
			bump_line_number();
			number_shown = 1'b1;
		end
		if (opts.show_nonprinting && b != CH_TAB && b != CH_NL) begin
			if (b >= CH_SPACE && b < CH_DEL) begin
				run.push_back(b);
			end else if (b == CH_DEL) begin
				run.push_back(CH_CARET);
				run.push_back(CH_QMARK);
			end else if (b == CH_FF) begin
				run.push_back(CH_M);
				run.push_back(CH_DASH);
				run.push_back(CH_CARET);
				run.push_back(CH_QMARK);
			end else if (b >= CH_META_P) begin
				run.push_back(CH_M);
				run.push_back(CH_DASH);
				run.push_back(b - 8'd128);
			end else if (b >= CH_HIGH) begin
				run.push_back(CH_M);
				run.push_back(CH_DASH);
				run.push_back(CH_CARET);
				run.push_back(b - 8'd64);
			end else begin
				run.push_back(CH_CARET);
				run.push_back(b + 8'd64);
			end
		end else begin
			if (opts.show_line_ends && b == CH_NL)
				run.push_back(CH_DOLLAR);
			if (opts.show_tabs && b == CH_TAB) begin
				run.push_back(CH_CARET);
				run.push_back(CH_I);
			end else begin
				run.push_back(b);
				last_literal = b;
				number_shown = 1'b0;
			end
		end
		for (i = 0; i < run.size(); i++)
			listing_q.push_back('{out_byte: run[i], run_last: (i == run.size() - 1)});
	endfunction

	always @(posedge clk) begin : check_out
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (listing_q.size() == 0) begin
				if (mismatches < 10)
					$display("beat %0d: nothing expected, got byte %h last %b",
						beats_checked, out_data.out_byte, out_data.run_last);
				mismatches++;
			end else begin
				want = listing_q.pop_front();
				if (out_data.out_byte !== want.out_byte || out_data.run_last !== want.run_last) begin
					if (mismatches < 10)
						$display("beat %0d: expected byte %h last %b, got byte %h last %b",
							beats_checked, want.out_byte, want.run_last,
							out_data.out_byte, out_data.run_last);
					mismatches++;
				end
				beats_checked++;
			end
		end
	end

	// keeps in_valid high across back-to-back beats
	task automatic send_beat(input logic [7:0] b, input logic fs);
		if ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= '{in_byte: b, file_start: fs};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_listing(b, fs);
		bytes_sent++;
	endtask

	// hold off input until every owed beat is out
	task automatic settle();
		in_valid <= 1'b0;
		while (listing_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		case (r)
			REG_NUM_ALL:       opts.number_all_lines = v;
			REG_NUM_NONBLANK:  opts.number_nonblank_lines = v;
			REG_SQUEEZE:       opts.squeeze_blank = v;
			REG_SHOW_ENDS:     opts.show_line_ends = v;
			REG_SHOW_TABS:     opts.show_tabs = v;
			REG_SHOW_NONPRINT: opts.show_nonprinting = v;
			default: ;
		endcase
	endtask

	task automatic apply_config(input cfg_t c);
		write_reg(REG_NUM_ALL, c.number_all_lines);
		write_reg(REG_NUM_NONBLANK, c.number_nonblank_lines);
		write_reg(REG_SQUEEZE, c.squeeze_blank);
		write_reg(REG_SHOW_ENDS, c.show_line_ends);
		write_reg(REG_SHOW_TABS, c.show_tabs);
		write_reg(REG_SHOW_NONPRINT, c.show_nonprinting);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic cfg_t pick_config();
		int r;
		r = $urandom_range(7);
		if (r == 0)
			return '1;
		if (r == 1)
			return '0;
		return cfg_t'($urandom_range(63));
	endfunction

	// mostly line-shaped text, with escapes and blank runs mixed in
	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 22)
			return CH_NL;
		if (r < 30)
			return CH_TAB;
		if (r < 70)
			return 8'($urandom_range(32, 126));
		return 8'($urandom_range(255));
	endfunction

	task automatic test_plain_text();
		apply_config('0);
		send_beat(8'h41, 1'b1);
		send_beat(CH_NL, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(CH_FF, 1'b0);
		settle();
	endtask

	task automatic test_line_numbers();
		cfg_t c;
		c = '0;
		c.number_all_lines = 1'b1;
		c.show_line_ends = 1'b1;
		apply_config(c);
		send_beat(CH_NL, 1'b0);
		send_beat(CH_NL, 1'b0);
		send_beat(8'h78, 1'b0);
		send_beat(CH_NL, 1'b0);
		settle();
	endtask

	task automatic test_squeeze_nonblank();
		cfg_t c;
		c = '0;
		c.number_all_lines = 1'b1;
		c.number_nonblank_lines = 1'b1;
		c.squeeze_blank = 1'b1;
		apply_config(c);
		send_beat(CH_NL, 1'b0);
		send_beat(CH_NL, 1'b0);
		send_beat(CH_NL, 1'b0);
		send_beat(8'h79, 1'b1);
		send_beat(CH_NL, 1'b0);
		send_beat(CH_NL, 1'b0);
		settle();
	endtask

	task automatic test_visible_notation();
		logic [7:0] codes [12] = '{CH_TAB, 8'h00, 8'h1F, CH_DEL, CH_HIGH, 8'h9F,
			CH_META_P, 8'hFE, CH_FF, 8'h7E, CH_SPACE, CH_NL};
		apply_config('1);
		foreach (codes[i])
			send_beat(codes[i], 1'b0);
		settle();
	endtask

	task automatic test_random_text(input int src_pct, input int sink_pct, input int n_items);
		int k;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (k = 0; k < n_items; k++) begin
			if (k % BURST_ITEMS == 0) begin
				settle();
				apply_config(pick_config());
			end
			send_beat(pick_text_byte(), ($urandom_range(99) < 4));
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_NUM_ALL;
		cfg_data = 1'b0;
		opts = '0;
		line_bcd = BCD_ONE;
		last_literal = CH_NL;
		number_shown = 1'b0;
		blank_run = 2'd0;
		src_idle_pct = 18;
		sink_stall_pct = 77;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_text();
		test_line_numbers();
		test_squeeze_nonblank();
		test_visible_notation();
		test_random_text(18, 77, 100);
		test_random_text(77, 18, 100);
		test_random_text(0, 0, 100);

		$display("sent %0d text bytes under %0d option settings, checked %0d listing beats",
			bytes_sent, settings_used, beats_checked);
		$display("covered numbering, squeeze, escapes and file starts under three stall mixes");
		if (mismatches == 0 && listing_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d bad beats, %0d beats never seen", mismatches, listing_q.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
